@@ hdl/ffha_pkg.sv @@
package ffha_pkg;

    localparam int HEAP_BYTES_DEF    = 4096;
    localparam int GRANULE_BYTES_DEF = 8;

    localparam int REQ_W     = 13;
    localparam int OFF_W     = 12;
    localparam int ST_W      = 2;
    localparam int DIV_W     = 14;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef logic [ST_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_NOFIT = 2'd1;
    localparam status_t ST_ZERO  = 2'd2;
    localparam status_t ST_BAD   = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

@@ hdl/ffha_div.sv @@
module ffha_div
    import ffha_pkg::*;
#(
    parameter int DIVISOR = GRANULE_BYTES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DIV_W-1:0]           dividend,
    output logic                       done,
    output logic [DIV_W-1:0]           quotient,
    output logic [$clog2(DIVISOR)-1:0] remainder
);

    localparam int RMW = $clog2(DIVISOR);
    localparam int SH  = DIV_W + RMW;
    localparam int RCW = DIV_W + 1;
    localparam int PRW = SH + DIV_W;

    localparam logic [RCW-1:0] RECIP = RCW'(((1 << SH) + DIVISOR - 1) / DIVISOR);

    logic [PRW-1:0]   product;
    logic [DIV_W-1:0] quot_reg;
    logic [DIV_W-1:0] quot_next;
    logic [DIV_W-1:0] back;
    logic [DIV_W-1:0] diff;
    logic [RMW-1:0]   rem_reg;
    logic [RMW-1:0]   rem_next;
    logic             done_reg;
    logic             done_next;

    // reciprocal multiply, exact over the whole dividend range
    assign product   = PRW'(dividend) * PRW'(RECIP);
    assign quot_next = product[PRW-1:SH];
    assign back      = quot_next * DIV_W'(DIVISOR);
    assign diff      = dividend - back;
    assign rem_next  = diff[RMW-1:0];
    assign done_next = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/ffha_hdr_mem.sv @@
module ffha_hdr_mem
    import ffha_pkg::*;
#(
    parameter int DEPTH = HEAP_BYTES_DEF / GRANULE_BYTES_DEF,
    parameter int WIDTH = 11
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/first_fit_heap_allocator_core.sv @@
// channel  | direction | fields (lowest bit up)
// s_axis   | in        | tdata: request_size[12:0], free_offset[24:13], zero pad
//          |           | tuser: mode
// m_axis   | out       | tdata: payload_offset[11:0], status[13:12], zero pad
//
// One word at a time; ready is low from acceptance until the result is registered.
// After acceptance a word passes through the granule divide, a read and an evaluate
// step per chunk header walked, the header update and the registering of the result;
// the walk is paced by the single read port of the header memory.
// Reset: entry 0 reads as one free chunk spanning the heap until first written.
// A result waiting on m_axis holds the sequencer only at its final step.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
    parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // request_size, free_offset
    input  logic                 s_axis_tuser,  // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // payload_offset, status
);

    localparam int NUM_GRAN = HEAP_BYTES / GRANULE_BYTES;
    localparam int AW       = $clog2(NUM_GRAN);
    localparam int SW       = $clog2(NUM_GRAN + 1);
    localparam int EW       = SW + 1;
    localparam int WW       = ((SW > DIV_W) ? SW : DIV_W) + 2;
    localparam int BW       = $clog2(HEAP_BYTES + 1);
    localparam int PW       = (BW > OFF_W) ? BW : OFF_W;
    localparam int RMW      = $clog2(GRANULE_BYTES);
    localparam int PAD_W    = M_TDATA_W - OFF_W - ST_W;

    localparam logic [EW-1:0] RESET_ENT = {SW'(NUM_GRAN), 1'b0};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_WRD  = 4'd2;
    localparam logic [3:0] S_WEV  = 4'd3;
    localparam logic [3:0] S_SPL  = 4'd4;
    localparam logic [3:0] S_NRD  = 4'd5;
    localparam logic [3:0] S_NEV  = 4'd6;
    localparam logic [3:0] S_HWR  = 4'd7;
    localparam logic [3:0] S_PRD  = 4'd8;
    localparam logic [3:0] S_PEV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]       state_reg,     state_next;
    logic             mode_reg,      mode_next;
    logic [OFF_W-1:0] off_reg,       off_next;
    logic [WW-1:0]    need_reg,      need_next;
    logic [WW-1:0]    h_reg,         h_next;
    logic [WW-1:0]    pos_reg,       pos_next;
    logic [WW-1:0]    prev_reg,      prev_next;
    logic             have_prev_reg, have_prev_next;
    logic [WW-1:0]    sz_reg,        sz_next;
    logic [WW-1:0]    rem_reg,       rem_next;
    status_t          res_st_reg,    res_st_next;
    logic [OFF_W-1:0] res_pay_reg,   res_pay_next;
    logic             init0_reg,     init0_next;
    logic             rd_zero_reg,   rd_zero_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_st_reg,    out_st_next;
    logic [OFF_W-1:0] out_pay_reg,   out_pay_next;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [RMW-1:0]   div_rem;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    mem_q;

    logic [REQ_W-1:0] in_req;
    logic [OFF_W-1:0] in_off;
    logic             in_take;
    logic [EW-1:0]    ent;
    logic [SW-1:0]    ent_size;
    logic             ent_al;
    logic [WW-1:0]    cs_w;
    logic [WW-1:0]    pos_cs;
    logic [WW-1:0]    pos_need;
    logic [WW-1:0]    fit_rem;
    logic [PW-1:0]    pay_full;
    logic             off_bad;
    logic             out_free;

    assign in_req  = s_axis_tdata[REQ_W-1:0];
    assign in_off  = s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
    assign in_take = s_axis_tvalid && s_axis_tready;

    assign ent      = (rd_zero_reg && !init0_reg) ? RESET_ENT : mem_q;
    assign ent_size = ent[EW-1:1];
    assign ent_al   = ent[0];
    assign cs_w     = WW'(ent_size);
    assign pos_cs   = pos_reg + cs_w;
    assign pos_need = pos_reg + need_reg;
    assign fit_rem  = cs_w - need_reg;
    assign pay_full = PW'(pos_reg + WW'(1)) * PW'(GRANULE_BYTES);
    assign off_bad  = (off_reg < OFF_W'(GRANULE_BYTES))
                   || (PW'(off_reg) >= PW'(HEAP_BYTES))
                   || (div_rem != '0);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign div_start    = in_take && !(s_axis_tuser == MODE_ALLOC && in_req == '0);
    assign div_dividend = (s_axis_tuser == MODE_FREE) ? DIV_W'(in_off)
                        : DIV_W'(in_req) + DIV_W'(GRANULE_BYTES - 1);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        off_next       = off_reg;
        need_next      = need_reg;
        h_next         = h_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sz_next        = sz_reg;
        rem_next       = rem_reg;
        res_st_next    = res_st_reg;
        res_pay_next   = res_pay_reg;
        init0_next     = init0_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_pay_next   = out_pay_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg[AW-1:0];
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = pos_reg[AW-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    mode_next    = s_axis_tuser;
                    off_next     = in_off;
                    res_pay_next = '0;
                    if (s_axis_tuser == MODE_ALLOC && in_req == '0)
                    begin
                        res_st_next = ST_ZERO;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pos_next       = '0;
                    have_prev_next = 1'b0;
                    need_next      = WW'(div_quot) + WW'(1);
                    h_next         = WW'(div_quot) - WW'(1);
                    if (mode_reg == MODE_FREE && off_bad)
                    begin
                        res_st_next = ST_BAD;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
            end
            S_WRD:
            begin
                if (pos_reg >= WW'(NUM_GRAN))
                begin
                    res_st_next = (mode_reg == MODE_FREE) ? ST_BAD : ST_NOFIT;
                    state_next  = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_WEV;
                end
            end
            S_WEV:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (cs_w == '0)
                    begin
                        res_st_next = ST_NOFIT;
                        state_next  = S_FIN;
                    end
                    else if (!ent_al && cs_w >= need_reg)
                    begin
                        wr_en        = 1'b1;
                        res_st_next  = ST_OK;
                        res_pay_next = pay_full[OFF_W-1:0];
                        rem_next     = fit_rem;
                        if (fit_rem >= WW'(2) && pos_need < WW'(NUM_GRAN))
                        begin
                            wr_data    = {need_reg[SW-1:0], 1'b1};
                            state_next = S_SPL;
                        end
                        else
                        begin
                            wr_data    = {ent_size, 1'b1};
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_cs;
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    if (pos_reg == h_reg)
                    begin
                        if (!ent_al)
                        begin
                            res_st_next = ST_BAD;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            sz_next    = cs_w;
                            pos_next   = pos_cs;
                            state_next = (pos_cs < WW'(NUM_GRAN)) ? S_NRD : S_HWR;
                        end
                    end
                    else if (cs_w == '0 || pos_reg > h_reg)
                    begin
                        res_st_next = ST_BAD;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        prev_next      = pos_reg;
                        have_prev_next = 1'b1;
                        pos_next       = pos_cs;
                        state_next     = S_WRD;
                    end
                end
            end
            S_SPL:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_need[AW-1:0];
                wr_data    = {rem_reg[SW-1:0], 1'b0};
                state_next = S_FIN;
            end
            S_NRD:
            begin
                rd_en      = 1'b1;
                state_next = S_NEV;
            end
            S_NEV:
            begin
                if (!ent_al)
                begin
                    sz_next = sz_reg + cs_w;
                end
                state_next = S_HWR;
            end
            S_HWR:
            begin
                wr_en       = 1'b1;
                wr_addr     = h_reg[AW-1:0];
                wr_data     = {sz_reg[SW-1:0], 1'b0};
                res_st_next = ST_OK;
                state_next  = have_prev_reg ? S_PRD : S_FIN;
            end
            S_PRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = prev_reg[AW-1:0];
                state_next = S_PEV;
            end
            S_PEV:
            begin
                if (!ent_al)
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[AW-1:0];
                    wr_data = {SW'(cs_w + sz_reg), 1'b0};
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_pay_next   = res_pay_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0)
        begin
            init0_next = 1'b1;
        end
    end

    assign rd_zero_next = (rd_addr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init0_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init0_reg     <= init0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        off_reg       <= off_next;
        need_reg      <= need_next;
        h_reg         <= h_next;
        pos_reg       <= pos_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        sz_reg        <= sz_next;
        rem_reg       <= rem_next;
        res_st_reg    <= res_st_next;
        res_pay_reg   <= res_pay_next;
        out_st_reg    <= out_st_next;
        out_pay_reg   <= out_pay_next;
        if (rd_en)
        begin
            rd_zero_reg <= rd_zero_next;
        end
    end

    ffha_div #(
        .DIVISOR (GRANULE_BYTES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ffha_hdr_mem #(
        .DEPTH (NUM_GRAN),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_st_reg, out_pay_reg};

endmodule

@@ hdl/ffha_checker.sv @@
module ffha_checker
    import ffha_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a word was taken");

    a_ready_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("ready dropped with no word offered");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    a_pay_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[OFF_W-1:0] != '0))
            |-> (m_axis_tdata[OFF_W+ST_W-1:OFF_W] == ST_OK))
        else $error("non-zero payload offset with failing status");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
